/* rtl/bbs_pkg.sv */
// Package for the bzip2 block boundary scanner.
// Holds field widths, reset patterns, result kinds and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package bbs_pkg;

    // Fixed widths of the stream patterns and result fields
    localparam int MagicBits    = 48;
    localparam int CrcBits      = 32;
    localparam int FieldPosBits = 40;
    localparam int CrcCountBits = 6;

    // Reset values of the match patterns (first stream bit is the MSB)
    localparam logic [MagicBits-1:0] BlockMagicReset = 48'h314159265359;
    localparam logic [MagicBits-1:0] EndMagicReset   = 48'h177245385090;

    // Result kind codes
    typedef enum logic {
        KIND_BOUNDARY = 1'b0,
        KIND_CRC      = 1'b1
    } kind_t;

    // Configuration register indexes
    typedef enum logic {
        CFG_BLOCK_MAGIC = 1'b0,
        CFG_END_MAGIC   = 1'b1
    } cfg_index_t;

endpackage

/* rtl/bzip2_block_boundary_scanner.sv */
// Top level of the bzip2 block boundary scanner.
// Scans a bit stream for block and end-of-stream magics and reports boundaries and the CRC.
// Depends on bbs_pkg.
`timescale 1ns / 1ps

// Takes one compressed-stream bit per input beat (s_tdata[0]) and reports, on the
// output stream, each block boundary (start positions of a magic and of the next
// block or end magic) and finally the 32-bit stream CRC that follows the
// end-of-stream magic. After the CRC beat, further bits are accepted and ignored
// until reset. The block takes one bit per clock cycle while the output is not
// stalled: a bit is registered at the input, then a single stage does the window
// shift, the two 48-bit compares and the position subtract, and writes the output
// register. The input keeps accepting while a result waits, until the input register
// is also full. Positions are bit counts from the start of the stream, saturating at
// the counter width, and reported in 40 bits. The match patterns may be rewritten
// through the cfg port while the block is idle.
module bzip2_block_boundary_scanner
    import bbs_pkg::*;
#(
    parameter int POSITION_BITS = 40
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    // Configuration write port
    input  logic                    cfg_we,
    input  logic                    cfg_index,
    input  logic [MagicBits-1:0]    cfg_data,
    // Input stream
    input  logic                    s_tvalid,
    output logic                    s_tready,
    input  logic [7:0]              s_tdata,    // [0] bit_in, [7:1] zero
    // Output stream
    output logic                    m_tvalid,
    input  logic                    m_tready,
    output logic [111:0]            m_tdata,    // [39:0] start_pos, [79:40] end_pos,
                                                // [111:80] crc_value
    output logic [0:0]              m_tuser     // [0] kind
);

    localparam int PosExtBits = (POSITION_BITS > FieldPosBits) ? POSITION_BITS : FieldPosBits;
    localparam logic [POSITION_BITS-1:0] PosMax = {POSITION_BITS{1'b1}};

    // Configuration registers
    logic [MagicBits-1:0] block_magic_reg;
    logic [MagicBits-1:0] end_magic_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            block_magic_reg <= BlockMagicReset;
            end_magic_reg   <= EndMagicReset;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_BLOCK_MAGIC: block_magic_reg <= cfg_data;
                CFG_END_MAGIC:   end_magic_reg   <= cfg_data;
                default:         block_magic_reg <= block_magic_reg;
            endcase
        end
    end

    // Input register and pipeline flow
    logic in_valid_reg;
    logic in_bit_reg;
    logic advance;

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (s_tready)
        begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_bit_reg <= s_tdata[0];
        end
    end

    // Scanner state
    logic [MagicBits-1:0]     window_reg,    window_next;
    logic [POSITION_BITS-1:0] pos_reg,       pos_next;
    logic [FieldPosBits-1:0]  prev_hit_reg,  prev_hit_next;
    logic [CrcBits-1:0]       crc_shift_reg, crc_shift_next;
    logic [CrcCountBits-1:0]  crc_left_reg,  crc_left_next;
    logic                     capturing_reg, capturing_next;
    logic                     finished_reg,  finished_next;

    // Result register contents
    logic                     emit;
    kind_t                    res_kind;
    logic [FieldPosBits-1:0]  res_start;
    logic [FieldPosBits-1:0]  res_end;
    logic [CrcBits-1:0]       res_crc;

    logic [PosExtBits-1:0]    pos_diff;
    logic [FieldPosBits-1:0]  hit_pos;
    logic                     window_full;
    logic                     is_end;
    logic                     is_block;

    // Per-bit scan: shift, compare, compute hit position
    always_comb
    begin
        window_next    = window_reg;
        pos_next       = pos_reg;
        prev_hit_next  = prev_hit_reg;
        crc_shift_next = crc_shift_reg;
        crc_left_next  = crc_left_reg;
        capturing_next = capturing_reg;
        finished_next  = finished_reg;
        emit           = 1'b0;
        res_kind       = KIND_BOUNDARY;
        res_start      = prev_hit_reg;
        res_end        = '0;
        res_crc        = '0;

        pos_diff    = PosExtBits'(pos_reg) + PosExtBits'(!(pos_reg == PosMax))
                      - PosExtBits'(MagicBits);
        hit_pos     = pos_diff[FieldPosBits-1:0];
        window_next = {window_reg[MagicBits-2:0], in_bit_reg};
        window_full = 1'b0;
        is_end      = 1'b0;
        is_block    = 1'b0;

        if (finished_reg)
        begin
            window_next = window_reg;
        end
        else
        begin
            if (pos_reg != PosMax)
            begin
                pos_next = pos_reg + 1'b1;
            end

            if (capturing_reg)
            begin
                // CRC capture: bits only fill the shift register
                window_next    = window_reg;
                crc_shift_next = {crc_shift_reg[CrcBits-2:0], in_bit_reg};
                if (crc_left_reg != '0)
                begin
                    crc_left_next = crc_left_reg - 1'b1;
                end
                if (crc_left_next == '0)
                begin
                    capturing_next = 1'b0;
                    finished_next  = 1'b1;
                    emit           = 1'b1;
                    res_kind       = KIND_CRC;
                    res_crc        = crc_shift_next;
                end
            end
            else
            begin
                // Magic search once the window holds a full pattern
                window_full = (PosExtBits'(pos_next) >= PosExtBits'(MagicBits));
                is_end      = window_full && (window_next == end_magic_reg);
                is_block    = window_full && (window_next == block_magic_reg);
                if (is_end || is_block)
                begin
                    if (prev_hit_reg != '0)
                    begin
                        emit    = 1'b1;
                        res_end = hit_pos;
                    end
                    prev_hit_next = hit_pos;
                end
                if (is_end)
                begin
                    capturing_next = 1'b1;
                    crc_left_next  = CrcCountBits'(CrcBits);
                    crc_shift_next = '0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            window_reg    <= '0;
            pos_reg       <= '0;
            prev_hit_reg  <= '0;
            crc_shift_reg <= '0;
            crc_left_reg  <= '0;
            capturing_reg <= 1'b0;
            finished_reg  <= 1'b0;
        end
        else if (advance)
        begin
            window_reg    <= window_next;
            pos_reg       <= pos_next;
            prev_hit_reg  <= prev_hit_next;
            crc_shift_reg <= crc_shift_next;
            crc_left_reg  <= crc_left_next;
            capturing_reg <= capturing_next;
            finished_reg  <= finished_next;
        end
    end

    // Output register
    logic                    out_valid_reg, out_valid_next;
    kind_t                   out_kind_reg;
    logic [FieldPosBits-1:0] out_start_reg;
    logic [FieldPosBits-1:0] out_end_reg;
    logic [CrcBits-1:0]      out_crc_reg;

    assign out_valid_next = advance ? emit : (out_valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && emit)
        begin
            out_kind_reg  <= res_kind;
            out_start_reg <= res_start;
            out_end_reg   <= res_end;
            out_crc_reg   <= res_crc;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = {out_crc_reg, out_end_reg, out_start_reg};
    assign m_tuser[0] = out_kind_reg;

    // Checks on scanner state and results
    a_crc_beat_finishes: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_CRC) |-> finished_reg)
        else $error("CRC result present without finished state");

    a_capture_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        capturing_reg |-> (!finished_reg && crc_left_reg != '0))
        else $error("CRC capture active with no bits left or after finish");

    a_boundary_start: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_kind_reg == KIND_BOUNDARY) |-> (out_start_reg != '0))
        else $error("boundary reported from a zero start position");

    a_finished_frozen: assert property (@(posedge clk) disable iff (!rst_n)
        finished_reg |=> (finished_reg && $stable(pos_reg) && $stable(window_reg)))
        else $error("state changed after stream end");

endmodule
